FILE: hw/rtl/rrsp_pkg.sv
// ----------------------------------------------------------------------------
// rrsp_pkg: shared types and constants
// Byte codes, event and element type codes, and the controller/datapath
// command and status structs of the reply stream parser.
// ----------------------------------------------------------------------------
package rrsp_pkg;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_PAYLOAD = 3'd1;
  localparam logic [2:0] EV_SCALAR  = 3'd2;
  localparam logic [2:0] EV_NIL     = 3'd3;
  localparam logic [2:0] EV_ARRAY   = 3'd4;
  localparam logic [2:0] EV_ERROR   = 3'd5;

  localparam logic [2:0] T_ERROR   = 3'd0;
  localparam logic [2:0] T_STATUS  = 3'd1;
  localparam logic [2:0] T_INTEGER = 3'd2;
  localparam logic [2:0] T_BULK    = 3'd3;
  localparam logic [2:0] T_ARRAY   = 3'd4;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_TYPE  = 2'd1;
  localparam logic [1:0] ERR_DEPTH = 2'd2;

  // Datapath operations on the number and counter registers.
  typedef struct packed {
    logic num_clear;   // start a new number line
    logic num_byte;    // feed a number line byte
    logic num_end;     // a CR ends the number (no more sign)
    logic bulk_load;   // load bulk counter from the parsed length
    logic bulk_dec;    // one bulk data byte transferred
    logic push;        // push an array count
    logic pop;         // complete an element, pop finished arrays
  } rrsp_cmd_t;

  typedef struct packed {
    logic [63:0] num_value;   // signed value of the current number line
    logic        num_is_neg;  // num_value bit 63
    logic        num_is_m1;   // num_value is -1
    logic        num_is_zero;
    logic        bulk_zero_nxt; // bulk length would be zero after load
    logic        bulk_last;   // this data byte is the last one
    logic        can_push;    // level_ptr below the stack top
    logic        reply_done;  // pop would empty the stack
    logic [3:0]  level;
  } rrsp_stat_t;

endpackage

FILE: hw/rtl/resp_reply_stream_parser_core.sv
// ----------------------------------------------------------------------------
// resp_reply_stream_parser_core: byte-serial reply stream parser
// Top level: handshakes, configuration register and output register.
// ----------------------------------------------------------------------------
// One byte is taken per clock cycle while in_ready is high, and its result
// is in the output register in the next cycle; a new byte is accepted while
// the previous result waits as long as the output register is empty or being
// drained. The whole parse step for a byte (state machine, 64-bit accumulate,
// stack pop by priority over the STACK_LEVELS entries) is combinational.
module resp_reply_stream_parser_core #(
  parameter int STACK_LEVELS = 9,
  parameter int COUNT_BITS   = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_max_nesting,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_event_res,
  output logic [2:0]  out_elem_type,
  output logic [7:0]  out_payload,
  output logic signed [63:0] out_value,
  output logic [3:0]  out_level,
  output logic        out_reply_done,
  output logic [1:0]  out_error_code
);
  import rrsp_pkg::*;

  logic       step;
  logic [3:0] max_nest_r;
  rrsp_cmd_t  cmd;
  rrsp_stat_t stat;
  logic [2:0] ev, et;
  logic [7:0] pl;
  logic [63:0] val;
  logic [3:0] lvl;
  logic       done;
  logic [1:0] err;

  assign in_ready  = !out_valid || out_ready;
  assign step      = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_nest_r <= 4'd8;
    end else if (cfg_valid) begin
      max_nest_r <= cfg_max_nesting;
    end
  end

  rrsp_ctrl #(.STACK_LEVELS(STACK_LEVELS)) u_ctrl (
    .clk, .rst_n, .step, .in_byte, .max_nesting(max_nest_r), .stat, .cmd,
    .ev, .et, .pl, .val, .lvl, .done, .err
  );

  rrsp_datapath #(.STACK_LEVELS(STACK_LEVELS), .COUNT_BITS(COUNT_BITS)) u_dp (
    .clk, .rst_n, .in_byte, .cmd, .stat
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_event_res  <= ev;
      out_elem_type  <= et;
      out_payload    <= pl;
      out_value      <= val;
      out_level      <= lvl;
      out_reply_done <= done;
      out_error_code <= err;
    end
  end

`ifndef SYNTH
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code != ERR_NONE |-> out_event_res == EV_ERROR)
    else $error("error code without error event");
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    step && out_valid && out_error_code != ERR_NONE |=> out_error_code != ERR_NONE)
    else $error("sticky error cleared");
  a_done_evt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_reply_done |-> out_event_res != EV_PAYLOAD
      && out_event_res != EV_ERROR)
    else $error("reply done on wrong event");
`endif

endmodule

FILE: hw/rtl/rrsp_datapath.sv
// ----------------------------------------------------------------------------
// rrsp_datapath: number accumulator, bulk counter and nesting stack
// Executes controller commands; the stack pop is resolved by priority over
// the entries that are exactly one (they complete with this element).
// ----------------------------------------------------------------------------
module rrsp_datapath #(
  parameter int STACK_LEVELS = 9,
  parameter int COUNT_BITS   = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [7:0]           in_byte,
  input  rrsp_pkg::rrsp_cmd_t  cmd,
  output rrsp_pkg::rrsp_stat_t stat
);
  import rrsp_pkg::*;

  localparam int LW = $clog2(STACK_LEVELS);
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  logic [63:0] accum_r, accum_nxt;
  logic        neg_r, neg_nxt, bad_r, bad_nxt, first_r, first_nxt;
  logic [COUNT_BITS-1:0] bulk_r, bulk_nxt;
  logic [LW-1:0] lp_r, lp_nxt;
  logic [COUNT_BITS-1:0] cnt_r [STACK_LEVELS];
  logic [63:0] num_v, sat_v;
  logic [COUNT_BITS-1:0] sat_c;
  logic        is_digit;
  logic [LW-1:0] pop_lp;
  logic        pop_all;

  assign is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
  assign num_v = bad_r ? '1 : (neg_r ? (64'd0 - accum_r) : accum_r);
  assign sat_v = num_v;
  assign sat_c = (sat_v > {{(64-COUNT_BITS){1'b0}}, CMAX}) ? CMAX
                 : sat_v[COUNT_BITS-1:0];

  // Find the deepest level whose count stays nonzero after decrement.
  always_comb begin
    pop_lp  = '0;
    pop_all = 1'b1;
    for (int i = 0; i < STACK_LEVELS; i++) begin
      if (LW'(i) < lp_r && cnt_r[i] > COUNT_BITS'(1)) begin
        pop_lp  = LW'(i + 1);
        pop_all = 1'b0;
      end
    end
  end

  always_comb begin
    accum_nxt = accum_r;
    neg_nxt   = neg_r;
    bad_nxt   = bad_r;
    first_nxt = first_r;
    bulk_nxt  = bulk_r;
    lp_nxt    = lp_r;
    if (cmd.num_clear) begin
      accum_nxt = '0;
      neg_nxt   = 1'b0;
      bad_nxt   = 1'b0;
      first_nxt = 1'b1;
    end
    if (cmd.num_end) first_nxt = 1'b0;
    if (cmd.num_byte) begin
      first_nxt = 1'b0;
      if (first_r && (in_byte == CH_MINUS || in_byte == CH_PLUS)) begin
        if (in_byte == CH_MINUS) neg_nxt = 1'b1;
      end else if (is_digit) begin
        if (!bad_r) accum_nxt = (accum_r << 3) + (accum_r << 1)
                                + {60'd0, in_byte[3:0]};
      end else begin
        bad_nxt = 1'b1;
      end
    end
    if (cmd.bulk_load) begin
      accum_nxt = num_v;
      neg_nxt   = 1'b0;
      bad_nxt   = 1'b0;
      bulk_nxt  = sat_c;
    end
    if (cmd.bulk_dec && bulk_r != '0) bulk_nxt = bulk_r - COUNT_BITS'(1);
    if (cmd.push) lp_nxt = lp_r + LW'(1);
    if (cmd.pop) lp_nxt = pop_lp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r <= '0;
      neg_r   <= 1'b0;
      bad_r   <= 1'b0;
      first_r <= 1'b0;
      bulk_r  <= '0;
      lp_r    <= '0;
    end else begin
      accum_r <= accum_nxt;
      neg_r   <= neg_nxt;
      bad_r   <= bad_nxt;
      first_r <= first_nxt;
      bulk_r  <= bulk_nxt;
      lp_r    <= lp_nxt;
    end
  end

  // Only the count just below the pop point is decremented; entries at or
  // above the pop point are dead and need no update.
  always_ff @(posedge clk) begin
    for (int i = 0; i < STACK_LEVELS; i++) begin
      if (cmd.push && LW'(i) == lp_r) begin
        cnt_r[i] <= sat_c;
      end else if (cmd.pop && LW'(i) < lp_r && LW'(i) + LW'(1) == pop_lp
                   && !pop_all) begin
        cnt_r[i] <= cnt_r[i] - COUNT_BITS'(1);
      end
    end
  end

  always_comb begin
    stat.num_value     = num_v;
    stat.num_is_neg    = num_v[63];
    stat.num_is_m1     = (num_v == '1);
    stat.num_is_zero   = (num_v == '0);
    stat.bulk_zero_nxt = (sat_c == '0);
    stat.bulk_last     = (bulk_r <= COUNT_BITS'(1));
    stat.can_push      = (lp_r < LW'(STACK_LEVELS - 1));
    stat.reply_done    = pop_all;
    stat.level         = 4'(lp_r);
  end

endmodule

FILE: hw/rtl/rrsp_ctrl.sv
// ----------------------------------------------------------------------------
// rrsp_ctrl: parse state machine
// Walks the type byte, line, CR and bulk phases, issues datapath commands and
// forms each byte's result.
// ----------------------------------------------------------------------------
module rrsp_ctrl #(
  parameter int STACK_LEVELS = 9
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [7:0]           in_byte,
  input  logic [3:0]           max_nesting,
  input  rrsp_pkg::rrsp_stat_t stat,
  output rrsp_pkg::rrsp_cmd_t  cmd,
  output logic [2:0]           ev,
  output logic [2:0]           et,
  output logic [7:0]           pl,
  output logic [63:0]          val,
  output logic [3:0]           lvl,
  output logic                 done,
  output logic [1:0]           err
);
  import rrsp_pkg::*;

  typedef enum logic [2:0] {
    S_TYPE, S_LINE, S_LINE_CR, S_TAIL, S_BULK_DATA, S_BULK_SKIP1, S_BULK_SKIP2
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] type_r, type_nxt;
  logic [1:0] sticky_r, sticky_nxt;
  logic [3:0] limit;
  logic       text;

  assign limit = (max_nesting > 4'(STACK_LEVELS - 1)) ? 4'(STACK_LEVELS - 1)
                 : max_nesting;
  assign text  = (type_r == T_ERROR) || (type_r == T_STATUS);

  always_comb begin
    state_nxt  = state_r;
    type_nxt   = type_r;
    sticky_nxt = sticky_r;
    cmd  = '0;
    ev   = EV_NONE;
    et   = type_r;
    pl   = '0;
    val  = '0;
    lvl  = stat.level;
    done = 1'b0;
    if (sticky_r == ERR_NONE) begin
      case (state_r)
        S_TYPE: begin
          case (in_byte)
            CH_MINUS:  type_nxt = T_ERROR;
            CH_PLUS:   type_nxt = T_STATUS;
            CH_COLON:  type_nxt = T_INTEGER;
            CH_DOLLAR: type_nxt = T_BULK;
            CH_STAR:   type_nxt = T_ARRAY;
            default:   sticky_nxt = ERR_TYPE;
          endcase
          if (sticky_nxt == ERR_NONE && type_nxt == T_ARRAY
              && stat.level >= limit) begin
            sticky_nxt = ERR_DEPTH;
            type_nxt   = type_r;
          end
          if (sticky_nxt == ERR_NONE) begin
            et = type_nxt;
            cmd.num_clear = 1'b1;
            state_nxt = S_LINE;
          end else begin
            type_nxt = type_r;
          end
        end
        S_LINE, S_TAIL: begin
          if (in_byte == CH_CR) begin
            state_nxt   = S_LINE_CR;
            cmd.num_end = 1'b1;
          end else if (state_r == S_LINE) begin
            if (text) begin
              ev = EV_PAYLOAD;
              pl = in_byte;
            end else begin
              cmd.num_byte = 1'b1;
            end
          end
        end
        S_LINE_CR: begin
          if (in_byte == CH_LF) begin
            if (text) begin
              ev = EV_SCALAR;
              cmd.pop = 1'b1;
            end else if (type_r == T_INTEGER) begin
              ev = EV_SCALAR;
              val = stat.num_value;
              cmd.pop = 1'b1;
            end else if (type_r == T_BULK) begin
              if (stat.num_is_neg) begin
                ev = EV_NIL;
                val = stat.num_value;
                cmd.pop = 1'b1;
              end else begin
                cmd.bulk_load = 1'b1;
                state_nxt = stat.bulk_zero_nxt ? S_BULK_SKIP1 : S_BULK_DATA;
              end
            end else begin
              val = stat.num_value;
              if (stat.num_is_m1) begin
                ev = EV_NIL;
                cmd.pop = 1'b1;
              end else begin
                ev = EV_ARRAY;
                if (!stat.num_is_neg && !stat.num_is_zero && stat.can_push) begin
                  cmd.push = 1'b1;
                  state_nxt = S_TYPE;
                end else begin
                  cmd.pop = 1'b1;
                end
              end
            end
            if (cmd.pop) begin
              done = stat.reply_done;
              state_nxt = S_TYPE;
            end
          end else if (in_byte != CH_CR) begin
            if (text) begin
              ev = EV_PAYLOAD;
              pl = in_byte;
              state_nxt = S_LINE;
            end else begin
              state_nxt = S_TAIL;
            end
          end
        end
        S_BULK_DATA: begin
          ev = EV_PAYLOAD;
          pl = in_byte;
          cmd.bulk_dec = 1'b1;
          if (stat.bulk_last) state_nxt = S_BULK_SKIP1;
        end
        S_BULK_SKIP1: state_nxt = S_BULK_SKIP2;
        S_BULK_SKIP2: begin
          // The accumulator still holds the bulk length.
          ev = EV_SCALAR;
          val = stat.num_value;
          cmd.pop = 1'b1;
          done = stat.reply_done;
          state_nxt = S_TYPE;
        end
        default: state_nxt = S_TYPE;
      endcase
    end
    if (sticky_nxt != ERR_NONE) begin
      ev = EV_ERROR; et = T_ERROR; pl = '0; val = '0; lvl = '0; done = 1'b0;
      cmd = '0;
    end
    err = sticky_nxt;
    if (!step) cmd = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_TYPE;
      type_r   <= T_ERROR;
      sticky_r <= ERR_NONE;
    end else if (step) begin
      state_r  <= state_nxt;
      type_r   <= type_nxt;
      sticky_r <= sticky_nxt;
    end
  end

endmodule

FILE: test/tb_resp_reply_stream_parser_core.sv
// ----------------------------------------------------------------------------
// tb_resp_reply_stream_parser_core: reply stream parser testbench
// Feeds directed and randomly generated reply streams, at several nesting
// limits and with random stalls on both channels. Each result is checked field
// by field against a cycle-free model of the parser state or a typed row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_resp_reply_stream_parser_core;
  import rrsp_pkg::*;

  typedef enum logic [2:0] {
    M_TYPE, M_LINE, M_LINE_CR, M_TAIL, M_BULK_DATA, M_SKIP1, M_SKIP2
  } pmode_t;

  typedef struct packed {
    logic [2:0]  ev;
    logic [2:0]  et;
    logic [7:0]  pl;
    logic [63:0] val;
    logic [3:0]  lvl;
    logic        done;
    logic [1:0]  err;
  } event_t;

  typedef struct {
    logic [7:0] b;
    bit         typed;
    event_t     want;
  } stim_row_t;

  localparam logic [63:0] COUNT_MAX = 64'hFFFF_FFFF;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_max_nesting = 4'd8;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_event_res;
  logic [2:0]  out_elem_type;
  logic [7:0]  out_payload;
  logic signed [63:0] out_value;
  logic [3:0]  out_level;
  logic        out_reply_done;
  logic [1:0]  out_error_code;

  resp_reply_stream_parser_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_byte(in_byte),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_max_nesting(cfg_max_nesting),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_event_res(out_event_res), .out_elem_type(out_elem_type),
    .out_payload(out_payload), .out_value(out_value), .out_level(out_level),
    .out_reply_done(out_reply_done), .out_error_code(out_error_code)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Parser state as seen by the predictor.
  pmode_t      p_mode;
  logic [2:0]  p_type;
  logic [3:0]  p_lvl;
  logic [63:0] p_cnt [9];
  logic [63:0] p_acc;
  logic        p_neg, p_bad, p_first;
  logic [63:0] p_bulk;
  logic [1:0]  p_sticky;
  logic [3:0]  p_maxn;

  event_t      expected_events[$];
  logic [7:0]  stream_q[$];
  stim_row_t   directed_rows[$];
  int          mismatches = 0;
  bit          quiet = 1'b0;
  int          gen_lim;

  function automatic logic [63:0] sat_count(input logic [63:0] v);
    return (v > COUNT_MAX) ? COUNT_MAX : v;
  endfunction

  // Completes the current element and closes every array it was the last child of.
  function automatic logic close_elem();
    int lp;
    lp = p_lvl;
    p_mode = M_TYPE;
    while (lp > 0) begin
      if (p_cnt[lp-1] > 0) p_cnt[lp-1] = p_cnt[lp-1] - 1;
      if (p_cnt[lp-1] != 0) begin
        p_lvl = lp;
        return 1'b0;
      end
      lp--;
    end
    p_lvl = 0;
    return 1'b1;
  endfunction

  function automatic event_t parse_step(input logic [7:0] b);
    event_t r;
    logic [63:0] v;
    logic [3:0] lim;
    logic [2:0] t;
    bit is_t, text;
    r = '0;
    r.et = p_type;
    r.lvl = p_lvl;
    lim = (p_maxn > 4'd8) ? 4'd8 : p_maxn;
    text = (p_type == T_ERROR) || (p_type == T_STATUS);
    if (p_sticky == ERR_NONE) begin
      case (p_mode)
        M_TYPE: begin
          is_t = 1'b1;
          t = T_ERROR;
          case (b)
            CH_MINUS:  t = T_ERROR;
            CH_PLUS:   t = T_STATUS;
            CH_COLON:  t = T_INTEGER;
            CH_DOLLAR: t = T_BULK;
            CH_STAR:   t = T_ARRAY;
            default:   is_t = 1'b0;
          endcase
          if (!is_t) p_sticky = ERR_TYPE;
          else if (t == T_ARRAY && p_lvl >= lim) p_sticky = ERR_DEPTH;
          else begin
            p_type = t;
            r.et = t;
            p_acc = '0;
            p_neg = 1'b0;
            p_bad = 1'b0;
            p_first = 1'b1;
            p_mode = M_LINE;
          end
        end
        M_LINE, M_TAIL: begin
          if (b == CH_CR) begin
            p_mode = M_LINE_CR;
            p_first = 1'b0;
          end else if (p_mode == M_TAIL) begin
          end else if (text) begin
            r.ev = EV_PAYLOAD;
            r.pl = b;
          end else begin
            if (p_first && (b == CH_MINUS || b == CH_PLUS)) begin
              if (b == CH_MINUS) p_neg = 1'b1;
            end else if (b >= CH_ZERO && b <= CH_NINE) begin
              if (!p_bad) p_acc = p_acc * 10 + 64'(b - CH_ZERO);
            end else begin
              p_bad = 1'b1;
            end
            p_first = 1'b0;
          end
        end
        M_LINE_CR: begin
          if (b == CH_LF) begin
            v = p_bad ? '1 : (p_neg ? -p_acc : p_acc);
            if (text) begin
              r.ev = EV_SCALAR;
              r.done = close_elem();
            end else if (p_type == T_INTEGER) begin
              r.ev = EV_SCALAR;
              r.val = v;
              r.done = close_elem();
            end else if (p_type == T_BULK) begin
              if (v[63]) begin
                r.ev = EV_NIL;
                r.val = v;
                r.done = close_elem();
              end else begin
                p_acc = v;
                p_neg = 1'b0;
                p_bad = 1'b0;
                p_bulk = sat_count(v);
                p_mode = (p_bulk != 0) ? M_BULK_DATA : M_SKIP1;
              end
            end else begin
              r.val = v;
              if (v == '1) begin
                r.ev = EV_NIL;
                r.done = close_elem();
              end else begin
                r.ev = EV_ARRAY;
                if (!v[63] && v != 0 && p_lvl < 8) begin
                  p_cnt[p_lvl] = sat_count(v);
                  p_lvl = p_lvl + 1;
                  p_mode = M_TYPE;
                end else begin
                  r.done = close_elem();
                end
              end
            end
          end else if (b == CH_CR) begin
            // The earlier CR was line content; stay here.
          end else if (text) begin
            r.ev = EV_PAYLOAD;
            r.pl = b;
            p_mode = M_LINE;
          end else begin
            p_mode = M_TAIL;
          end
        end
        M_BULK_DATA: begin
          r.ev = EV_PAYLOAD;
          r.pl = b;
          if (p_bulk > 0) p_bulk = p_bulk - 1;
          if (p_bulk == 0) p_mode = M_SKIP1;
        end
        M_SKIP1: p_mode = M_SKIP2;
        default: begin
          r.ev = EV_SCALAR;
          r.val = p_acc;
          r.done = close_elem();
        end
      endcase
    end
    if (p_sticky != ERR_NONE) begin
      r = '0;
      r.ev = EV_ERROR;
    end
    r.err = p_sticky;
    return r;
  endfunction

  // ---------------- stream generation ----------------
  function automatic void push_text(input string s);
    foreach (s[i]) stream_q.push_back(s[i]);
  endfunction

  function automatic void push_digits(input int n);
    for (int i = 0; i < n; i++) stream_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
  endfunction

  function automatic void gen_int_line();
    int k;
    logic [7:0] c;
    k = $urandom_range(0, 9);
    case (k)
      0, 1, 2, 3: push_text($sformatf("%0d", int'($urandom_range(0, 2000)) - 1000));
      4: begin
        push_text("+");
        push_digits($urandom_range(1, 4));
      end
      5: begin
        if ($urandom_range(0, 1)) push_text("-");
        push_digits($urandom_range(19, 22));
      end
      6: ;
      7: begin
        push_digits($urandom_range(0, 2));
        c = 8'($urandom_range(0, 255));
        stream_q.push_back((c == CH_CR) ? 8'h71 : c);
        push_digits($urandom_range(0, 2));
      end
      8: begin
        // A lone CR ends the number; junk follows up to the real CRLF.
        push_digits($urandom_range(1, 3));
        stream_q.push_back(CH_CR);
        for (int i = 0; i < $urandom_range(1, 3); i++) begin
          c = 8'($urandom_range(0, 255));
          stream_q.push_back((c == CH_LF || c == CH_CR) ? 8'h78 : c);
        end
      end
      default: push_text($urandom_range(0, 1) ? "-9223372036854775808" : "9223372036854775807");
    endcase
    push_text("\r\n");
  endfunction

  function automatic void gen_elem(input int depth);
    int k, n;
    logic [7:0] c, prev;
    k = $urandom_range(0, 9);
    if (k >= 7 && depth >= gen_lim) k = 4;
    if (k <= 1) begin
      push_text(k == 0 ? "+" : "-");
      prev = 8'h00;
      n = $urandom_range(0, 6);
      for (int i = 0; i < n; i++) begin
        c = 8'($urandom_range(0, 255));
        if (prev == CH_CR && c == CH_LF) c = 8'h7A;
        stream_q.push_back(c);
        prev = c;
      end
      push_text("\r\n");
    end else if (k <= 3) begin
      push_text(":");
      gen_int_line();
    end else if (k <= 6) begin
      push_text("$");
      if ($urandom_range(0, 7) == 0) begin
        push_text($urandom_range(0, 1) ? "-1\r\n" : "-7\r\n");
      end else begin
        n = ($urandom_range(0, 15) == 0) ? 40 : $urandom_range(0, 8);
        push_text($sformatf("%0d\r\n", n));
        for (int i = 0; i < n; i++) stream_q.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 5) == 0) begin
          stream_q.push_back(8'($urandom_range(0, 255)));
          stream_q.push_back(8'($urandom_range(0, 255)));
        end else begin
          push_text("\r\n");
        end
      end
    end else begin
      push_text("*");
      k = $urandom_range(0, 7);
      if (k == 0) push_text("-1\r\n");
      else if (k == 1) push_text($sformatf("-%0d\r\n", $urandom_range(2, 5)));
      else begin
        n = $urandom_range(0, 3);
        push_text($sformatf("%0d\r\n", n));
        for (int i = 0; i < n; i++) gen_elem(depth + 1);
      end
    end
  endfunction

  // ---------------- driving ----------------
  task automatic send_byte(input logic [7:0] b, input bit typed, input event_t want);
    event_t r;
    if (!quiet && $urandom_range(0, 11) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (!in_ready);
    r = parse_step(b);
    expected_events.push_back(typed ? want : r);
  endtask

  // Leaves in_valid high after the last transfer; the caller drops it.
  task automatic send_stream();
    while (stream_q.size() > 0) send_byte(stream_q.pop_front(), 1'b0, '0);
  endtask

  task automatic write_max_nesting(input logic [3:0] v);
    while (expected_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_max_nesting <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    p_maxn = v;
    gen_lim = (v > 4'd8) ? 8 : v;
  endtask

  function automatic void add_rows(input string s);
    stim_row_t row;
    foreach (s[i]) begin
      row.b = s[i];
      row.typed = 1'b0;
      row.want = '0;
      directed_rows.push_back(row);
    end
  endfunction

  function automatic void add_typed(input logic [7:0] b, input logic [2:0] ev,
                                    input logic [2:0] et, input logic [63:0] val,
                                    input logic done);
    stim_row_t row;
    row.b = b;
    row.typed = 1'b1;
    row.want = '{ev: ev, et: et, pl: 8'h00, val: val, lvl: 4'd0, done: done, err: ERR_NONE};
    directed_rows.push_back(row);
  endfunction

  // Result channel stalls.
  initial begin
    @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    event_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = '{ev: out_event_res, et: out_elem_type, pl: out_payload, val: out_value,
              lvl: out_level, done: out_reply_done, err: out_error_code};
      if (expected_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer: %p", got);
      end else begin
        want = expected_events.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected ev=%0d et=%0d pl=%h val=%h lvl=%0d done=%b err=%0d, got ev=%0d et=%0d pl=%h val=%h lvl=%0d done=%b err=%0d",
                     want.ev, want.et, want.pl, want.val, want.lvl, want.done, want.err,
                     got.ev, got.et, got.pl, got.val, got.lvl, got.done, got.err);
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int sent;
    logic [7:0] c;
    logic [3:0] settings [3];
    p_mode = M_TYPE;
    p_type = T_ERROR;
    p_lvl = '0;
    foreach (p_cnt[i]) p_cnt[i] = '0;
    p_acc = '0;
    p_neg = 1'b0;
    p_bad = 1'b0;
    p_first = 1'b0;
    p_bulk = '0;
    p_sticky = ERR_NONE;
    p_maxn = 4'd8;
    gen_lim = 8;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: signed integer, lone CR in a status line, empty bulk, nil array.
    add_typed(CH_COLON, EV_NONE, T_INTEGER, 64'd0, 1'b0);
    add_rows("-5\r");
    add_typed(CH_LF, EV_SCALAR, T_INTEGER, -64'sd5, 1'b1);
    add_rows("+A\rB\r\n");
    add_rows("$0\r\n\r");
    add_typed(CH_LF, EV_SCALAR, T_BULK, 64'd0, 1'b1);
    add_rows("*-1\r");
    add_typed(CH_LF, EV_NIL, T_ARRAY, '1, 1'b1);
    add_rows(":1x\r\n");
    foreach (directed_rows[i])
      send_byte(directed_rows[i].b, directed_rows[i].typed, directed_rows[i].want);
    in_valid <= 1'b0;

    settings[0] = 4'd1;
    settings[1] = 4'($urandom_range(2, 7));
    settings[2] = 4'd8;
    for (int ph = 0; ph < 4; ph++) begin
      write_max_nesting(ph < 3 ? settings[ph] : 4'($urandom_range(1, 8)));
      if (ph == 3) quiet = 1'b1;
      sent = 0;
      while (sent < 360) begin
        gen_elem(0);
        sent += stream_q.size();
        send_stream();
      end
      in_valid <= 1'b0;
    end

    // Finally drive the parser into its sticky error state.
    if ($urandom_range(0, 1)) begin
      write_max_nesting(4'd1);
      push_text("*1\r\n*");
    end else begin
      do c = 8'($urandom_range(0, 255));
      while (c == CH_MINUS || c == CH_PLUS || c == CH_COLON || c == CH_DOLLAR || c == CH_STAR);
      stream_q.push_back(c);
    end
    for (int i = 0; i < 15; i++) stream_q.push_back(8'($urandom_range(0, 255)));
    send_stream();
    in_valid <= 1'b0;

    while (expected_events.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
